// ===== rtl/srwn_pkg.sv =====
// Shared widths, codes and controller/datapath handshake types for the
// sparse row weight normalizer. No dependencies.
`timescale 1ns / 1ps

package srwn_pkg;

  localparam int MODE_W    = 2;
  localparam int ROW_W     = 10;
  localparam int WEIGHT_W  = 17;
  localparam int SUM_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int LIMIT_W   = 11;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;
  localparam int CMP_W     = 17;   // wide enough for row, limit and row count

  // item modes
  localparam logic [MODE_W-1:0] MODE_ACC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SUM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  localparam logic [WEIGHT_W-1:0] Q_ONE   = 17'h10000;
  localparam logic [SUM_W-1:0]    SUM_MAX = 32'hFFFF_FFFF;

  // divider: 33-bit dividend, one quotient bit per cycle
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 11'd1024;
  localparam logic [PADDR_W-1:0] ADDR_ROW_LIMIT = 2'd0;

  typedef struct packed {
    logic clr_step;   // write zero at the clear address, advance
    logic accept;     // latch item, issue table read
    logic exec;       // table data valid: update table, start divider
    logic div_step;   // one quotient bit
    logic out_load;   // move result into output register
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;   // clear address at last row
    logic needs_div;  // valid during exec
    logic div_last;   // valid during div_step
    logic out_free;   // output register can take a result this cycle
  } ctl_sts_t;

endpackage

// ===== rtl/srwn_in_if.sv =====
// Input channel for edge items: valid/ready plus the item fields.
// Depends on srwn_pkg.
`timescale 1ns / 1ps

interface srwn_in_if;
  logic                            valid;
  logic                            ready;
  logic [srwn_pkg::MODE_W-1:0]     mode;
  logic [srwn_pkg::ROW_W-1:0]      row_index;
  logic [srwn_pkg::WEIGHT_W-1:0]   weight;

  modport source (output valid, output mode, output row_index, output weight, input ready);
  modport sink   (input valid, input mode, input row_index, input weight, output ready);
endinterface

// ===== rtl/srwn_out_if.sv =====
// Result channel: valid/ready plus normalized weight, row sum and status.
// Depends on srwn_pkg.
`timescale 1ns / 1ps

interface srwn_out_if;
  logic                            valid;
  logic                            ready;
  logic [srwn_pkg::WEIGHT_W-1:0]   normalized_weight;
  logic [srwn_pkg::SUM_W-1:0]      row_sum;
  logic [srwn_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output normalized_weight, output row_sum, output status,
                  input ready);
  modport sink   (input valid, input normalized_weight, input row_sum, input status,
                  output ready);
endinterface

// ===== rtl/srwn_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module srwn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/srwn_datapath.sv =====
// Datapath: row sum table, range check, saturating add, radix-2 divider
// and output register. Depends on srwn_pkg and srwn_ram.
`timescale 1ns / 1ps

module srwn_datapath #(
  parameter int ROWS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  srwn_pkg::ctl_cmd_t               cmd,
  output srwn_pkg::ctl_sts_t               sts,
  input  logic [srwn_pkg::LIMIT_W-1:0]     row_limit,
  input  logic [srwn_pkg::MODE_W-1:0]      in_mode,
  input  logic [srwn_pkg::ROW_W-1:0]       in_row,
  input  logic [srwn_pkg::WEIGHT_W-1:0]    in_weight,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [srwn_pkg::WEIGHT_W-1:0]    out_norm,
  output logic [srwn_pkg::SUM_W-1:0]       out_sum,
  output logic [srwn_pkg::STATUS_W-1:0]    out_status
);

  localparam int AW = $clog2(ROWS);
  localparam int XW = (AW > srwn_pkg::ROW_W) ? AW : srwn_pkg::ROW_W;
  localparam logic [srwn_pkg::CMP_W-1:0] ROWS_V = srwn_pkg::CMP_W'(ROWS);
  localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);
  localparam int QW = srwn_pkg::DIV_STEPS;
  localparam int SW = srwn_pkg::SUM_W;

  // item registers
  logic [srwn_pkg::MODE_W-1:0]   cur_mode;
  logic [AW-1:0]                 cur_addr;
  logic [srwn_pkg::WEIGHT_W-1:0] cur_weight;
  logic                          cur_oob;

  logic [AW-1:0] clr_addr;
  logic [XW-1:0] in_row_x;
  logic [AW-1:0] in_addr;
  logic          in_oob;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic [SW-1:0] rd_data;

  logic [SW:0]   acc_wide;
  logic [SW-1:0] acc_sum;

  // divider
  logic [SW-1:0]                  div_d;
  logic [SW-1:0]                  rem;
  logic [QW-1:0]                  quot;
  logic [srwn_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [SW:0]                    trial;
  logic                           qbit;
  logic [SW:0]                    trial_sub;
  logic [QW-1:0]                  quot_next;
  logic [SW-1:0]                  rem_next;

  // pending result
  logic [srwn_pkg::WEIGHT_W-1:0] res_norm;
  logic [SW-1:0]                 res_sum;
  logic [srwn_pkg::STATUS_W-1:0] res_status;

  assign in_row_x = XW'(in_row);
  assign in_addr  = in_row_x[AW-1:0];
  assign in_oob   = (srwn_pkg::CMP_W'(in_row) >= srwn_pkg::CMP_W'(row_limit)) ||
                    (srwn_pkg::CMP_W'(in_row) >= ROWS_V);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_mode   <= in_mode;
      cur_addr   <= in_addr;
      cur_weight <= in_weight;
      cur_oob    <= in_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign acc_wide = {1'b0, rd_data} + (SW + 1)'(cur_weight);
  assign acc_sum  = acc_wide[SW] ? srwn_pkg::SUM_MAX : acc_wide[SW-1:0];

  assign wr_en   = cmd.clr_step ||
                   (cmd.exec && !cur_oob &&
                    (cur_mode == srwn_pkg::MODE_ACC || cur_mode == srwn_pkg::MODE_CLR));
  assign wr_addr = cmd.clr_step ? clr_addr : cur_addr;
  assign wr_data = (!cmd.clr_step && cur_mode == srwn_pkg::MODE_ACC) ? acc_sum : '0;

  srwn_ram #(
    .WIDTH (SW),
    .DEPTH (ROWS)
  ) u_sum_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.accept),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // restoring divide step: remainder stays below the divisor
  assign trial     = {rem, quot[QW-1]};
  assign trial_sub = trial - {1'b0, div_d};
  assign qbit      = (trial >= {1'b0, div_d});
  assign rem_next  = qbit ? trial_sub[SW-1:0] : trial[SW-1:0];
  assign quot_next = {quot[QW-2:0], qbit};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      div_d   <= rd_data;
      rem     <= '0;
      quot    <= {cur_weight, 16'b0};
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_next;
      quot    <= quot_next;
      div_cnt <= div_cnt + srwn_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_norm <= '0;
      if (cur_oob) begin
        res_sum    <= '0;
        res_status <= srwn_pkg::ST_RANGE;
      end else begin
        case (cur_mode)
          srwn_pkg::MODE_ACC: begin
            res_sum    <= acc_sum;
            res_status <= srwn_pkg::ST_OK;
          end
          srwn_pkg::MODE_NORM: begin
            if (rd_data == '0) begin
              res_sum    <= '0;
              res_status <= srwn_pkg::ST_ZERO_SUM;
            end else begin
              res_sum    <= rd_data;
              res_status <= srwn_pkg::ST_OK;
            end
          end
          srwn_pkg::MODE_CLR: begin
            res_sum    <= '0;
            res_status <= srwn_pkg::ST_OK;
          end
          default: begin
            res_sum    <= rd_data;
            res_status <= srwn_pkg::ST_OK;
          end
        endcase
      end
    end else if (cmd.div_step && sts.div_last) begin
      res_norm <= (quot_next > QW'(srwn_pkg::Q_ONE)) ? srwn_pkg::Q_ONE
                                                     : quot_next[srwn_pkg::WEIGHT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_norm   <= res_norm;
      out_sum    <= res_sum;
      out_status <= res_status;
    end
  end

  assign sts.clr_last  = (clr_addr == LAST_ROW);
  assign sts.needs_div = !cur_oob && (cur_mode == srwn_pkg::MODE_NORM) && (rd_data != '0);
  assign sts.div_last  = (div_cnt == srwn_pkg::DIV_CNT_W'(srwn_pkg::DIV_STEPS - 1));
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/srwn_ctrl.sv =====
// Controller: sequences table clearing, item execution, division and
// result hand-off. Depends on srwn_pkg.
`timescale 1ns / 1ps

module srwn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srwn_pkg::ctl_sts_t   sts,
  output srwn_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.needs_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/sparse_row_weight_normalizer.sv =====
// Sparse row weight normalizer: a normalize runs a radix-2 divider, and every item goes
// through IDLE, EXEC, DIV (normalize with a nonzero sum only) and DONE in that order.
// One item in flight; the next beat is taken in IDLE once DONE has moved the result into
// the output register, and DONE waits while that register holds an unaccepted result.
// Synchronous reset; a clearing pass then zeroes the row sum table with input held off;
// row_limit resets to 1024. Uses srwn_pkg, ifs, ctrl, datapath.
`timescale 1ns / 1ps

module sparse_row_weight_normalizer #(
  parameter int ROWS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  srwn_in_if.sink                         item,
  srwn_out_if.source                      result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srwn_pkg::PADDR_W-1:0]    paddr,
  input  logic [srwn_pkg::PDATA_W-1:0]    pwdata,
  output logic [srwn_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  srwn_pkg::ctl_cmd_t            cmd;
  srwn_pkg::ctl_sts_t            sts;
  logic [srwn_pkg::LIMIT_W-1:0]  row_limit;
  logic                          cfg_wr;

  // ---------------------------------------------------------------------
  // Register port. Zero-wait APB: a write lands on the access cycle.
  // Only row_limit exists; other addresses read zero and ignore writes.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == srwn_pkg::ADDR_ROW_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit <= srwn_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      row_limit <= pwdata[srwn_pkg::LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr == srwn_pkg::ADDR_ROW_LIMIT) ?
                  srwn_pkg::PDATA_W'(row_limit) : '0;

  // ---------------------------------------------------------------------
  // Controller: clear pass, then per item
  //   IDLE -> EXEC (table data back) -> [DIV] -> DONE (wait for slot)
  // ---------------------------------------------------------------------
  srwn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ---------------------------------------------------------------------
  // Datapath: range check at accept, table read/modify/write, divider,
  // output register that decouples the result beat from the next item.
  // ---------------------------------------------------------------------
  srwn_datapath #(
    .ROWS (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .row_limit  (row_limit),
    .in_mode    (item.mode),
    .in_row     (item.row_index),
    .in_weight  (item.weight),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_norm   (result.normalized_weight),
    .out_sum    (result.row_sum),
    .out_status (result.status)
  );

endmodule

// ===== rtl/srwn_checker.sv =====
// Port-level checks for the normalizer, attached with bind.
// Depends on srwn_pkg and sparse_row_weight_normalizer.
`timescale 1ns / 1ps

module srwn_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [srwn_pkg::WEIGHT_W-1:0]   normalized_weight,
  input logic [srwn_pkg::SUM_W-1:0]      row_sum,
  input logic [srwn_pkg::STATUS_W-1:0]   status
);

  // no result beat straight out of reset
  a_rst_no_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // table clear holds off input after reset
  a_rst_no_accept: assert property (@(posedge clk) rst |=> !item_ready)
    else $error("input ready during clearing pass");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(normalized_weight) && $stable(row_sum) && $stable(status))
    else $error("stalled result beat changed");

  a_norm_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> normalized_weight <= srwn_pkg::Q_ONE)
    else $error("normalized weight above 1.0");

  // error results carry zero payload, and no undefined status appears
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status == srwn_pkg::ST_OK ||
      ((status == srwn_pkg::ST_ZERO_SUM || status == srwn_pkg::ST_RANGE) &&
       normalized_weight == '0 && row_sum == '0))
    else $error("bad status or nonzero payload on error");

endmodule

bind sparse_row_weight_normalizer srwn_checker u_srwn_checker (
  .clk               (clk),
  .rst               (rst),
  .item_ready        (item.ready),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .normalized_weight (result.normalized_weight),
  .row_sum           (result.row_sum),
  .status            (result.status)
);
